// ===== rtl/idll_pkg.sv =====
// Shared types and constants of the indexed doubly linked list.
package idll_pkg;

  localparam int unsigned IdW = 10;

  typedef enum logic [1:0] {
    OP_INS_LEFT  = 2'd0,
    OP_INS_RIGHT = 2'd1,
    OP_REMOVE    = 2'd2,
    OP_READ      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_IGNORED    = 2'd1,
    ST_BAD_TARGET = 2'd2,
    ST_BAD_NEW    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SQ_CLEAR = 2'd0,
    SQ_IDLE  = 2'd1,
    SQ_EXEC  = 2'd2,
    SQ_FIN   = 2'd3
  } seq_t;

  // Classified command word passed from the front end to the back end
  typedef struct packed {
    op_t            op;
    logic [IdW-1:0] target;
    logic [IdW-1:0] new_id;
    logic           t_zero;
    logic           t_oor;
    logic           n_bad;
  } cmd_t;

  typedef struct packed {
    status_t        status;
    logic [IdW-1:0] prev_id;
    logic [IdW-1:0] next_id;
  } res_t;

endpackage

// ===== rtl/idll_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module idll_ram #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/idll_front.sv =====
// Front end: classify incoming words and hold them in a two-entry queue.
module idll_front #(
  parameter int unsigned MAX_ID = 1023
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     in_operation,
  input  logic [idll_pkg::IdW-1:0]       in_target_id,
  input  logic [idll_pkg::IdW-1:0]       in_new_id,
  input  logic                           clearing_i,
  output logic                           cmd_valid_o,
  output idll_pkg::cmd_t                 cmd_o,
  input  logic                           cmd_pop_i
);
  import idll_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept;
  cmd_t       cmd_new;

  // Classify: range checks against the top id are done once, here
  always_comb begin
    cmd_new.op     = op_t'(in_operation);
    cmd_new.target = in_target_id;
    cmd_new.new_id = in_new_id;
    cmd_new.t_zero = (in_target_id == '0);
    cmd_new.t_oor  = (32'(in_target_id) > MAX_ID);
    cmd_new.n_bad  = (in_new_id == '0) || (32'(in_new_id) > MAX_ID);
  end

  assign full   = (cnt_r == 2'd2) || clearing_i;
  assign accept = push && !full;

  always_comb begin
    wr_ptr_nxt = accept    ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop_i ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, accept} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= cmd_new;
    end
  end

  assign cmd_valid_o = (cnt_r != 2'd0);
  assign cmd_o       = q_r[rd_ptr_r];

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop_i |-> cnt_r != 2'd0)
    else $error("command taken from an empty queue");

endmodule

// ===== rtl/idll_back.sv =====
// Back end: link tables, id marks, operation sequencer and result queue.
module idll_back #(
  parameter int unsigned MAX_ID = 1023
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid_i,
  input  idll_pkg::cmd_t       cmd_i,
  output logic                 cmd_pop_o,
  output logic                 clearing_o,
  output logic                 empty,
  input  logic                 pop,
  output idll_pkg::res_t       res_o
);
  import idll_pkg::*;

  localparam int unsigned IdTop = (1 << IdW) - 1;
  localparam int unsigned Depth = (MAX_ID < IdTop) ? MAX_ID + 1 : IdTop + 1;
  localparam int unsigned AddrW = $clog2(Depth);

  localparam logic [1:0] MARK_FREE   = 2'd0;
  localparam logic [1:0] MARK_LISTED = 2'd1;
  localparam logic [1:0] MARK_GONE   = 2'd2;

  seq_t             state_r, state_nxt;
  cmd_t             cmd_r;
  logic [AddrW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [AddrW-1:0] left_r, left_nxt;
  logic [AddrW-1:0] right_r, right_nxt;

  // memory controls
  logic             rd_en;
  logic             pv_we, nx_we, mk_we;
  logic [AddrW-1:0] pv_wa, nx_wa, mk_wa;
  logic [AddrW-1:0] pv_wd, nx_wd;
  logic [1:0]       mk_wd;
  logic [AddrW-1:0] pv_q, nx_q;
  logic [1:0]       mk_t_q, mk_n_q;

  // decode of the command in flight
  logic [AddrW-1:0] t_a, n_a, left, right;
  logic             listed_t, anchor_ok, new_ok;

  logic             res_push;
  res_t             res_val;

  // result queue
  res_t             oq_r [2];
  logic             oq_wr_r, oq_rd_r;
  logic [1:0]       oq_cnt_r;
  logic             oq_pop;

  idll_ram #(.W(AddrW), .DEPTH(Depth)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
    .re(rd_en), .raddr(cmd_i.target[AddrW-1:0]), .rdata(pv_q)
  );

  idll_ram #(.W(AddrW), .DEPTH(Depth)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
    .re(rd_en), .raddr(cmd_i.target[AddrW-1:0]), .rdata(nx_q)
  );

  // Two copies of the id marks so target and new id are looked up together
  idll_ram #(.W(2), .DEPTH(Depth)) u_mark_t (
    .clk(clk), .we(mk_we), .waddr(mk_wa), .wdata(mk_wd),
    .re(rd_en), .raddr(cmd_i.target[AddrW-1:0]), .rdata(mk_t_q)
  );

  idll_ram #(.W(2), .DEPTH(Depth)) u_mark_n (
    .clk(clk), .we(mk_we), .waddr(mk_wa), .wdata(mk_wd),
    .re(rd_en), .raddr(cmd_i.new_id[AddrW-1:0]), .rdata(mk_n_q)
  );

  assign t_a       = cmd_r.target[AddrW-1:0];
  assign n_a       = cmd_r.new_id[AddrW-1:0];
  assign listed_t  = !cmd_r.t_zero && !cmd_r.t_oor && (mk_t_q == MARK_LISTED);
  assign anchor_ok = listed_t || (cmd_r.t_zero && (cmd_r.op == OP_INS_RIGHT));
  assign new_ok    = !cmd_r.n_bad && (mk_n_q == MARK_FREE);
  assign left      = (cmd_r.op == OP_INS_LEFT) ? pv_q : t_a;
  assign right     = (cmd_r.op == OP_INS_LEFT) ? t_a : nx_q;

  assign clearing_o = (state_r == SQ_CLEAR);

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    left_nxt    = left_r;
    right_nxt   = right_r;
    cmd_pop_o   = 1'b0;
    rd_en       = 1'b0;
    pv_we       = 1'b0;
    pv_wa       = '0;
    pv_wd       = '0;
    nx_we       = 1'b0;
    nx_wa       = '0;
    nx_wd       = '0;
    mk_we       = 1'b0;
    mk_wa       = '0;
    mk_wd       = MARK_FREE;
    res_push    = 1'b0;
    res_val     = '0;

    case (state_r)
      SQ_CLEAR: begin
        pv_we = 1'b1;
        pv_wa = clr_cnt_r;
        nx_we = 1'b1;
        nx_wa = clr_cnt_r;
        nx_wd = (clr_cnt_r == '0) ? AddrW'(1) : '0;
        mk_we = 1'b1;
        mk_wa = clr_cnt_r;
        mk_wd = (clr_cnt_r == AddrW'(1)) ? MARK_LISTED : MARK_FREE;
        if (clr_cnt_r == AddrW'(Depth - 1)) begin
          state_nxt = SQ_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + AddrW'(1);
        end
      end

      SQ_IDLE: begin
        if (cmd_valid_i && (oq_cnt_r != 2'd2)) begin
          cmd_pop_o = 1'b1;
          rd_en     = 1'b1;
          state_nxt = SQ_EXEC;
        end
      end

      SQ_EXEC: begin
        res_push       = 1'b1;
        res_val.status = ST_DONE;
        state_nxt      = SQ_IDLE;
        case (cmd_r.op)
          OP_INS_LEFT, OP_INS_RIGHT: begin
            if (!anchor_ok) begin
              res_val.status = ST_BAD_TARGET;
            end else if (!new_ok) begin
              res_val.status = ST_BAD_NEW;
            end else begin
              pv_we     = 1'b1;
              pv_wa     = n_a;
              pv_wd     = left;
              nx_we     = 1'b1;
              nx_wa     = n_a;
              nx_wd     = right;
              mk_we     = 1'b1;
              mk_wa     = n_a;
              mk_wd     = MARK_LISTED;
              left_nxt  = left;
              right_nxt = right;
              res_push  = 1'b0;
              state_nxt = SQ_FIN;
            end
          end
          OP_REMOVE: begin
            if (cmd_r.t_zero || cmd_r.t_oor) begin
              res_val.status = ST_BAD_TARGET;
            end else if (mk_t_q == MARK_GONE) begin
              res_val.status = ST_IGNORED;
            end else if (mk_t_q != MARK_LISTED) begin
              res_val.status = ST_BAD_TARGET;
            end else begin
              // unlink: neighbours point past the target
              nx_we           = 1'b1;
              nx_wa           = pv_q;
              nx_wd           = nx_q;
              pv_we           = (nx_q != '0);
              pv_wa           = nx_q;
              pv_wd           = pv_q;
              mk_we           = 1'b1;
              mk_wa           = t_a;
              mk_wd           = MARK_GONE;
              res_val.prev_id = IdW'(pv_q);
              res_val.next_id = IdW'(nx_q);
            end
          end
          OP_READ: begin
            if (cmd_r.t_zero) begin
              res_val.next_id = IdW'(nx_q);
            end else if (listed_t) begin
              res_val.prev_id = IdW'(pv_q);
              res_val.next_id = IdW'(nx_q);
            end else begin
              res_val.status = ST_BAD_TARGET;
            end
          end
          default: begin
            res_val.status = ST_BAD_TARGET;
          end
        endcase
      end

      SQ_FIN: begin
        // close the splice from the neighbours' side
        nx_we          = 1'b1;
        nx_wa          = left_r;
        nx_wd          = n_a;
        pv_we          = (right_r != '0);
        pv_wa          = right_r;
        pv_wd          = n_a;
        res_push       = 1'b1;
        res_val.status = ST_DONE;
        if (cmd_r.op == OP_INS_LEFT) begin
          res_val.prev_id = cmd_r.new_id;
          res_val.next_id = IdW'(nx_q);
        end else begin
          res_val.prev_id = cmd_r.t_zero ? '0 : IdW'(pv_q);
          res_val.next_id = cmd_r.new_id;
        end
        state_nxt = SQ_IDLE;
      end

      default: begin
        state_nxt = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= SQ_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r  <= left_nxt;
    right_r <= right_nxt;
    if (cmd_pop_o) begin
      cmd_r <= cmd_i;
    end
  end

  // Result queue: two entries, so one waiting result does not block the sequencer
  assign empty  = (oq_cnt_r == 2'd0);
  assign oq_pop = pop && !empty;
  assign res_o  = oq_r[oq_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (res_push) begin
        oq_wr_r <= ~oq_wr_r;
      end
      if (oq_pop) begin
        oq_rd_r <= ~oq_rd_r;
      end
      oq_cnt_r <= oq_cnt_r + {1'b0, res_push} - {1'b0, oq_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      oq_r[oq_wr_r] <= res_val;
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> oq_cnt_r != 2'd2)
    else $error("result pushed into a full queue");

  a_fin_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == SQ_FIN |-> $past(state_r) == SQ_EXEC)
    else $error("splice finish without execute");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res_val.status != ST_DONE) |->
      (res_val.prev_id == '0 && res_val.next_id == '0))
    else $error("failed operation reports links");

  a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_o |-> !cmd_pop_o)
    else $error("command taken during clearing pass");

endmodule

// ===== rtl/indexed_doubly_linked_list.sv =====
// Top level of the indexed doubly linked list of ids.
//
//  channel  handshake        accepted when       payload
//  -------  ---------------  ------------------  ---------------------------------
//  input    push / full      push && !full       in_operation, in_target_id,
//                                                in_new_id
//  result   empty / pop      pop && !empty       out_status, out_prev_id,
//                                                out_next_id
//
// The back end reads a word's table entries as it takes the word, then executes
// it; an insert that succeeds adds a finish state, since it writes up to four
// link entries and each link table has one write port. Reads of the link and
// mark tables are registered. After reset a clearing pass walks all min(MAX_ID,
// 1023) + 1 table entries, one entry a cycle; full stays high until it ends.
// The front queue and the result queue hold two words each, so either side
// may stall without stopping the other until its queue fills.
module indexed_doubly_linked_list #(
  parameter int unsigned MAX_ID = 1023
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  output logic                     full,
  input  logic [1:0]               in_operation,
  input  logic [idll_pkg::IdW-1:0] in_target_id,
  input  logic [idll_pkg::IdW-1:0] in_new_id,
  output logic                     empty,
  input  logic                     pop,
  output logic [1:0]               out_status,
  output logic [idll_pkg::IdW-1:0] out_prev_id,
  output logic [idll_pkg::IdW-1:0] out_next_id
);
  import idll_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic clearing;
  res_t res;

  // Front end: classify and queue incoming words
  idll_front #(.MAX_ID(MAX_ID)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_operation (in_operation),
    .in_target_id (in_target_id),
    .in_new_id    (in_new_id),
    .clearing_i   (clearing),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  // Back end: walk the link tables and queue the results
  idll_back #(.MAX_ID(MAX_ID)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .clearing_o  (clearing),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res)
  );

  // Drive the result word onto its ports
  assign out_status  = res.status;
  assign out_prev_id = res.prev_id;
  assign out_next_id = res.next_id;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench of the indexed doubly linked list of ids.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import idll_pkg::*;

  localparam int unsigned MaxId      = 1023;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned HoldOff    = 400;

  // Shadow copy of the link tables.
  // Every accepted word is applied here in order of acceptance, and the answer
  // it must produce is queued. Answers from the block are checked against the
  // head of that queue.
  class list_checker;
    logic [IdW-1:0] prev_link [1024];
    logic [IdW-1:0] next_link [1024];
    bit             in_list [1024];
    bit             ever_removed [1024];
    res_t           awaited_answers [$];
    int             listed_ids [$];
    int             gone_ids [$];
    int             errors;
    int             noted;

    function new();
      foreach (prev_link[i]) begin
        prev_link[i]    = '0;
        next_link[i]    = '0;
        in_list[i]      = 1'b0;
        ever_removed[i] = 1'b0;
      end
      // After reset the list holds id 1 alone
      next_link[0] = 10'd1;
      in_list[1]   = 1'b1;
      listed_ids.push_back(1);
      errors = 0;
      noted  = 0;
    endfunction

    function bit is_listed(logic [IdW-1:0] id);
      return id >= 1 && id <= MaxId && in_list[id];
    endfunction

    // Apply one word to the shadow tables and return the answer it gives
    function res_t apply_word(op_t op, logic [IdW-1:0] t, logic [IdW-1:0] nid);
      res_t           r;
      logic [IdW-1:0] left;
      logic [IdW-1:0] right;
      r.status  = ST_DONE;
      r.prev_id = '0;
      r.next_id = '0;
      case (op)
        OP_INS_LEFT, OP_INS_RIGHT: begin
          // The anchor is judged before the new id
          if (!(is_listed(t) || (t == 0 && op == OP_INS_RIGHT))) begin
            r.status = ST_BAD_TARGET;
          end else if (nid == 0 || nid > MaxId || in_list[nid] || ever_removed[nid]) begin
            r.status = ST_BAD_NEW;
          end else begin
            if (op == OP_INS_LEFT) begin
              left  = prev_link[t];
              right = t;
            end else begin
              left  = t;
              right = next_link[t];
            end
            prev_link[nid]  = left;
            next_link[nid]  = right;
            next_link[left] = nid;
            if (right != 0) prev_link[right] = nid;
            in_list[nid] = 1'b1;
            listed_ids.push_back(int'(nid));
            r.prev_id = (t == 0) ? '0 : prev_link[t];
            r.next_id = next_link[t];
          end
        end
        OP_REMOVE: begin
          if (t == 0 || t > MaxId) begin
            r.status = ST_BAD_TARGET;
          end else if (ever_removed[t]) begin
            r.status = ST_IGNORED;
          end else if (!in_list[t]) begin
            r.status = ST_BAD_TARGET;
          end else begin
            r.prev_id = prev_link[t];
            r.next_id = next_link[t];
            next_link[r.prev_id] = r.next_id;
            if (r.next_id != 0) prev_link[r.next_id] = r.prev_id;
            in_list[t]      = 1'b0;
            ever_removed[t] = 1'b1;
            foreach (listed_ids[i]) begin
              if (listed_ids[i] == t) begin
                listed_ids.delete(i);
                break;
              end
            end
            gone_ids.push_back(int'(t));
          end
        end
        default: begin
          if (t == 0) begin
            r.next_id = next_link[0];
          end else if (!is_listed(t)) begin
            r.status = ST_BAD_TARGET;
          end else begin
            r.prev_id = prev_link[t];
            r.next_id = next_link[t];
          end
        end
      endcase
      return r;
    endfunction

    function void note_command(op_t op, logic [IdW-1:0] t, logic [IdW-1:0] nid);
      awaited_answers.push_back(apply_word(op, t, nid));
      noted++;
    endfunction

    function void check_answer(status_t st, logic [IdW-1:0] p, logic [IdW-1:0] n);
      res_t want;
      if (awaited_answers.size() == 0) begin
        $error("answer with none awaited: status %0d prev_id %0d next_id %0d", st, p, n);
        errors++;
        return;
      end
      want = awaited_answers.pop_front();
      if (st != want.status) begin
        $error("status: expected %0d, got %0d", want.status, st);
        errors++;
      end
      if (p != want.prev_id) begin
        $error("prev_id: expected %0d, got %0d", want.prev_id, p);
        errors++;
      end
      if (n != want.next_id) begin
        $error("next_id: expected %0d, got %0d", want.next_id, n);
        errors++;
      end
    endfunction

    function int awaited();
      return awaited_answers.size();
    endfunction
  endclass

  // Every input is known from time zero
  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           push = 1'b0;
  logic           full;
  logic [1:0]     in_operation = '0;
  logic [IdW-1:0] in_target_id = '0;
  logic [IdW-1:0] in_new_id = '0;
  logic           empty;
  logic           pop = 1'b0;
  logic [1:0]     out_status;
  logic [IdW-1:0] out_prev_id;
  logic [IdW-1:0] out_next_id;

  list_checker sb = new();

  int burst_left = 0;
  int rx_cycle = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int cycles = 0;

  indexed_doubly_linked_list #(.MAX_ID(MaxId)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_operation (in_operation),
    .in_target_id (in_target_id),
    .in_new_id    (in_new_id),
    .empty        (empty),
    .pop          (pop),
    .out_status   (out_status),
    .out_prev_id  (out_prev_id),
    .out_next_id  (out_next_id)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offer one word and hold it until the block takes it.
  // The sender works in bursts: at the end of a burst, drop push for a random
  // gap (sometimes none) and pick the length of the next burst. Within a burst
  // push stays high from word to word, so it is never lowered and raised in
  // the same step.
  task automatic send(op_t op, logic [IdW-1:0] t, logic [IdW-1:0] nid);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    push         <= 1'b1;
    in_operation <= op;
    in_target_id <= t;
    in_new_id    <= nid;
    // Accepted at the first edge that sees full low
    do @(posedge clk); while (full);
    sb.note_command(op, t, nid);
  endtask

  // Any id now in the list, or the head where the list is empty
  function automatic logic [IdW-1:0] pick_listed();
    if (sb.listed_ids.size() == 0) return '0;
    return 10'(sb.listed_ids[$urandom_range(0, sb.listed_ids.size() - 1)]);
  endfunction

  // An id never inserted yet; fall back to any value once they grow scarce
  function automatic logic [IdW-1:0] pick_fresh();
    logic [IdW-1:0] id;
    for (int tries = 0; tries < 64; tries++) begin
      id = 10'($urandom_range(1, MaxId));
      if (!sb.in_list[id] && !sb.ever_removed[id]) return id;
    end
    return 10'($urandom_range(0, 1023));
  endfunction

  // Receiver: take answers on a pattern of its own.
  // The mode steps in turn through pop always, half the time, a quarter of
  // the time, three quarters. Once a few hundred words are in, hold pop low
  // for a long stretch so that both queues fill and full stalls the sender.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) sb.check_answer(status_t'(out_status), out_prev_id, out_next_id);
      rx_cycle++;
      if (!hold_done && sb.noted >= 400) begin
        hold_done = 1'b1;
        hold_left = HoldOff;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case ((rx_cycle / 97) % 4)
          0:       pop <= 1'b1;
          1:       pop <= ($urandom_range(0, 1) == 0);
          2:       pop <= ($urandom_range(0, 3) == 0);
          default: pop <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Watchdog: allow for the clearing pass, every word, the sender's gaps,
  // the receiver's stalls and the long hold-off, many times over
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    op_t            op;
    logic [IdW-1:0] t;
    logic [IdW-1:0] nid;
    int             pick;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words; the list starts as [1]
    send(OP_READ, 10'd0, 10'd0);            // head shows the first element
    send(OP_READ, 10'd1, 10'd1023);         // lone element
    send(OP_INS_LEFT, 10'd0, 10'd5);        // nothing stands left of the head
    send(OP_INS_RIGHT, 10'd0, 10'd2);       // insert at the front: [2 1]
    send(OP_INS_LEFT, 10'd1, 10'd3);        // [2 3 1]
    send(OP_INS_RIGHT, 10'd1, 10'd1023);    // append the top id: [2 3 1 1023]
    send(OP_INS_RIGHT, 10'd500, 10'd4);     // anchor not listed
    send(OP_INS_RIGHT, 10'd700, 10'd0);     // anchor judged before new id
    send(OP_INS_LEFT, 10'd1023, 10'd0);     // new id of zero
    send(OP_INS_LEFT, 10'd1, 10'd2);        // duplicate new id
    send(OP_REMOVE, 10'd0, 10'd0);          // head cannot go
    send(OP_REMOVE, 10'd600, 10'd0);        // never inserted
    send(OP_REMOVE, 10'd3, 10'd0);          // from the middle: [2 1 1023]
    send(OP_REMOVE, 10'd3, 10'd1023);       // already gone, ignored
    send(OP_INS_LEFT, 10'd1, 10'd3);        // once-removed id cannot return
    send(OP_READ, 10'd3, 10'd0);            // read of an id no longer listed
    send(OP_READ, 10'd1023, 10'd0);         // tail
    send(OP_REMOVE, 10'd2, 10'd0);          // first element
    send(OP_REMOVE, 10'd1023, 10'd0);       // last element
    send(OP_REMOVE, 10'd1, 10'd0);          // lone element: list now empty
    send(OP_READ, 10'd0, 10'd0);            // empty list
    send(OP_INS_RIGHT, 10'd0, 10'd512);     // insert into the empty list
    send(OP_INS_LEFT, 10'd512, 10'd4);      // left of the first element
    send(OP_INS_RIGHT, 10'd512, 10'd1022);  // right of the tail
    send(OP_READ, 10'd512, 10'd0);

    // Random words: mostly well-formed commands on listed ids with fresh new
    // ids, a share of broken ones and a share of plain noise
    for (int k = 0; k < 1000; k++) begin
      pick = $urandom_range(0, 99);
      nid  = 10'($urandom_range(0, 1023));
      if (pick < 10) begin
        op = op_t'($urandom_range(0, 3));
        t  = 10'($urandom_range(0, 1023));
      end else if (pick < 48) begin
        op  = ($urandom_range(0, 1) == 0) ? OP_INS_LEFT : OP_INS_RIGHT;
        t   = pick_listed();
        if (t == 0 || (op == OP_INS_RIGHT && $urandom_range(0, 7) == 0)) begin
          op = OP_INS_RIGHT;
          t  = '0;
        end
        nid = pick_fresh();
      end else if (pick < 75) begin
        op = OP_READ;
        t  = ($urandom_range(0, 9) == 0) ? '0 : pick_listed();
      end else if (pick < 92) begin
        op = OP_REMOVE;
        t  = pick_listed();
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            op = OP_REMOVE;
            t  = (sb.gone_ids.size() == 0) ? 10'($urandom_range(1, 1023))
                 : 10'(sb.gone_ids[$urandom_range(0, sb.gone_ids.size() - 1)]);
          end
          1: begin
            op  = OP_INS_RIGHT;
            t   = pick_listed();
            nid = pick_listed();
          end
          default: begin
            op = OP_INS_LEFT;
            t  = '0;
          end
        endcase
      end
      send(op, t, nid);
    end
    push <= 1'b0;

    // Drain: wait for every awaited answer, then watch for strays
    while (sb.awaited() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
